/* design/sst_pkg.sv */
// Shared types, constants and arithmetic helpers of the solar tracker servo stepper.
package sst_pkg;

    localparam int unsigned ADC_W  = 10;
    localparam int unsigned MV_W   = 11;
    localparam int unsigned THR_W  = 11;
    localparam int unsigned PAN_W  = 8;
    localparam int unsigned TILT_W = 7;
    localparam int unsigned LANES  = 4;

    localparam logic [THR_W-1:0] THR_RESET = 11'd550;

    localparam logic signed [PAN_W-1:0]  PAN_RESET  = 8'sd0;
    localparam logic signed [TILT_W-1:0] TILT_PARK  = -7'sd40;

    typedef enum logic [1:0] {
        ACT_NIGHT = 2'd0,
        ACT_PAN   = 2'd1,
        ACT_TILT  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // What one lane hands to the merging stage.
    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic [MV_W-1:0] mv90;
    } t_lane_res;

    // floor(code * 1100 / 1023) = code + floor(code * 77 / 1023).
    // floor(y / 1024) is the quotient or one short of it; the remainder against
    // 1023 is the low ten bits plus that estimate.
    function automatic logic [MV_W-1:0] to_mv(input logic [ADC_W-1:0] code);
        logic [16:0] y;
        logic [6:0]  q0;
        logic [10:0] rem;
        logic        corr;
        y    = 17'(code) * 17'd77;
        q0   = y[16:10];
        rem  = {1'b0, y[9:0]} + 11'(q0);
        corr = (rem >= 11'd1023);
        return MV_W'(code) + MV_W'(q0) + MV_W'(corr);
    endfunction

    // floor(9 * v / 10), with the division done as a multiply by 6554 / 65536,
    // exact for every 9 * v below 16384.
    function automatic logic [MV_W-1:0] tol90(input logic [MV_W-1:0] v);
        logic [13:0] p;
        logic [26:0] q;
        p = 14'(v) * 14'd9;
        q = 27'(p) * 27'd6554;
        return q[16+MV_W-1:16];
    endfunction

endpackage

/* design/sst_lane.sv */
// One sensor lane: converts a raw reading to millivolts and its ninety percent mark.
module sst_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [sst_pkg::ADC_W-1:0] i_adc,
    output sst_pkg::t_lane_res        o_res
);

    sst_pkg::t_lane_res r_res;
    sst_pkg::t_lane_res n_res;

    always_comb begin
        n_res.mv   = sst_pkg::to_mv(i_adc);
        n_res.mv90 = sst_pkg::tol90(n_res.mv);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

/* design/sst_merge.sv */
// Merging stage: combines the four lane results, decides the move and holds the servo positions.
module sst_merge (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic [sst_pkg::THR_W-1:0]                i_threshold,
    input  sst_pkg::t_lane_res [sst_pkg::LANES-1:0]  i_lane,
    output sst_pkg::t_action                         o_action,
    output logic signed [sst_pkg::PAN_W-1:0]         o_pan,
    output logic signed [sst_pkg::TILT_W-1:0]        o_tilt
);

    sst_pkg::t_action                    r_action;
    sst_pkg::t_action                    n_action;
    logic signed [sst_pkg::PAN_W-1:0]    r_pan;
    logic signed [sst_pkg::PAN_W-1:0]    n_pan;
    logic signed [sst_pkg::TILT_W-1:0]   r_tilt;
    logic signed [sst_pkg::TILT_W-1:0]   n_tilt;

    logic [12:0]                    sum;
    logic                           night;
    logic [1:0]                     best;
    logic [sst_pkg::MV_W-1:0]       bmax;
    logic                           pan_go;
    logic                           pan_pos;
    logic signed [sst_pkg::PAN_W:0] pan_next;
    logic                           pan_ok;
    logic [sst_pkg::MV_W-1:0]       upper;
    logic [sst_pkg::MV_W-1:0]       lower;
    logic                           tilt_up;
    logic                           tilt_dn;
    logic signed [sst_pkg::TILT_W:0] tilt_next;
    logic                           tilt_ok;

    always_comb begin
        sum = 13'(i_lane[0].mv) + 13'(i_lane[1].mv) + 13'(i_lane[2].mv) + 13'(i_lane[3].mv);
        night = (sum[12:2] < i_threshold);

        // Strictly greater only, so the first lane keeps a tie.
        best = 2'd0;
        bmax = i_lane[0].mv;
        for (int i = 1; i < sst_pkg::LANES; i++) begin
            if (i_lane[i].mv > bmax) begin
                bmax = i_lane[i].mv;
                best = 2'(i);
            end
        end
        pan_go = (i_lane[best].mv90 > i_lane[best ^ 2'd1].mv);

        // Right-hand sensors sit at even positions; a right sensor pans down when tilt is not negative.
        pan_pos  = best[0] ? !r_tilt[sst_pkg::TILT_W-1] : r_tilt[sst_pkg::TILT_W-1];
        pan_next = {r_pan[sst_pkg::PAN_W-1], r_pan} + (pan_pos ? 9'sd10 : -9'sd10);
        pan_ok   = (pan_next >= -9'sd90) && (pan_next <= 9'sd90);

        upper = sst_pkg::MV_W'((12'(i_lane[0].mv) + 12'(i_lane[1].mv)) >> 1);
        lower = sst_pkg::MV_W'((12'(i_lane[2].mv) + 12'(i_lane[3].mv)) >> 1);
        tilt_up = (lower <= upper) && (sst_pkg::tol90(upper) >= lower);
        tilt_dn = (lower > upper) && (sst_pkg::tol90(lower) >= upper);
        tilt_next = {r_tilt[sst_pkg::TILT_W-1], r_tilt} + (tilt_up ? 8'sd10 : -8'sd10);
        tilt_ok   = (tilt_next >= -8'sd40) && (tilt_next <= 8'sd40);

        n_action = sst_pkg::ACT_NONE;
        n_pan    = r_pan;
        n_tilt   = r_tilt;
        if (night) begin
            n_action = sst_pkg::ACT_NIGHT;
            n_tilt   = sst_pkg::TILT_PARK;
        end else if (pan_go) begin
            if (pan_ok) begin
                n_action = sst_pkg::ACT_PAN;
                n_pan    = pan_next[sst_pkg::PAN_W-1:0];
            end
        end else if ((tilt_up || tilt_dn) && tilt_ok) begin
            n_action = sst_pkg::ACT_TILT;
            n_tilt   = tilt_next[sst_pkg::TILT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan  <= sst_pkg::PAN_RESET;
            r_tilt <= sst_pkg::TILT_PARK;
        end else if (i_en) begin
            r_pan  <= n_pan;
            r_tilt <= n_tilt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_action <= n_action;
        end
    end

    assign o_action = r_action;
    assign o_pan    = r_pan;
    assign o_tilt   = r_tilt;

`ifndef SYNTH
    a_pan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pan >= -8'sd90) && (r_pan <= 8'sd90))
        else $error("pan position left its range");

    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tilt >= -7'sd40) && (r_tilt <= 7'sd40))
        else $error("tilt position left its range");

    a_night_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && night |=> (r_tilt == sst_pkg::TILT_PARK) && (r_pan == $past(r_pan)))
        else $error("night item did not park tilt or moved pan");

    a_pan_keeps_tilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !night && pan_go |=> (r_tilt == $past(r_tilt)))
        else $error("pan decision changed the tilt position");
`endif

endmodule

/* design/solar_tracker_servo_stepper_unit.sv */
// Top level of the solar tracker servo stepper: stream ports, threshold register and pipeline.
//
// Each input item carries four raw light readings; the block returns one result per item with
// the move taken and both servo angles after it. An item passes through two registered stages:
// four parallel sensor lanes convert the readings to millivolts, then a merging stage makes the
// night, pan or tilt decision and updates the servo positions held there. The lanes register
// the item when it is accepted, and the merging stage registers the result once the output is
// free and holds it while the output stalls; a new item is accepted every cycle while the
// output is taken. The light threshold resets to 550 mV and should only be written while no
// item is in flight.
module solar_tracker_servo_stepper_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sst_pkg::THR_W-1:0]  i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // adc_right_bottom[9:0], adc_left_bottom[19:10], adc_right_top[29:20], adc_left_top[39:30]
    input  logic [39:0]                i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // action[1:0], pan_angle[9:2], tilt_angle[16:10], zero fill[23:17]
    output logic [23:0]                o_m_axis_tdata
);

    logic [sst_pkg::THR_W-1:0] r_threshold;
    logic                      r_s1_valid;
    logic                      r_m_valid;

    logic s2_free;
    logic s1_free;
    logic accept;
    logic merge_en;

    sst_pkg::t_lane_res [sst_pkg::LANES-1:0] lane_res;
    sst_pkg::t_action                        action;
    logic signed [sst_pkg::PAN_W-1:0]        pan;
    logic signed [sst_pkg::TILT_W-1:0]       tilt;

    assign s2_free  = !r_m_valid || i_m_axis_tready;
    assign s1_free  = !r_s1_valid || s2_free;
    assign accept   = i_s_axis_tvalid && s1_free;
    assign merge_en = r_s1_valid && s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= sst_pkg::THR_RESET;
            r_s1_valid  <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            if (s1_free) begin
                r_s1_valid <= accept;
            end
            if (s2_free) begin
                r_m_valid <= r_s1_valid;
            end
        end
    end

    for (genvar g = 0; g < sst_pkg::LANES; g++) begin : g_lane
        sst_lane u_lane (
            .i_clk (i_clk),
            .i_en  (accept),
            .i_adc (i_s_axis_tdata[g*sst_pkg::ADC_W +: sst_pkg::ADC_W]),
            .o_res (lane_res[g])
        );
    end

    sst_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (merge_en),
        .i_threshold (r_threshold),
        .i_lane      (lane_res),
        .o_action    (action),
        .o_pan       (pan),
        .o_tilt      (tilt)
    );

    assign o_s_axis_tready = s1_free;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {7'd0, tilt, pan, action};

endmodule

/* dv/tb_solar_tracker_servo_stepper_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the solar tracker servo stepper: stream stimulus with angle prediction.
module tb_solar_tracker_servo_stepper_unit;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        sst_pkg::t_action   act;
        logic signed [7:0]  pan;
        logic signed [6:0]  tilt;
    } t_angles;

    // Tracks the servo angles the block should report and checks each result against them.
    class angle_scoreboard;
        t_angles     angles_due[$];
        int          pan_deg;
        int          tilt_deg;
        int unsigned thr_mv;
        int unsigned errors;
        int unsigned checked;
        int unsigned seen[4];

        function new();
            pan_deg  = 0;
            tilt_deg = -40;
            thr_mv   = 550;
            errors   = 0;
            checked  = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        static function int unsigned millivolts(logic [9:0] code);
            return (32'(code) * 1100) / 1023;
        endfunction

        static function int unsigned ninety_pct(int unsigned v);
            return (v * 9) / 10;
        endfunction

        function void note_reading(logic [39:0] d);
            int unsigned mv[4];
            int unsigned bright;
            int unsigned peak;
            int unsigned bottom_row;
            int unsigned top_row;
            int          delta;
            t_angles     e;
            e.act = sst_pkg::ACT_NONE;
            for (int i = 0; i < 4; i++) mv[i] = millivolts(d[i*10 +: 10]);
            if ((mv[0] + mv[1] + mv[2] + mv[3]) / 4 < thr_mv) begin
                tilt_deg = -40;
                e.act    = sst_pkg::ACT_NIGHT;
            end else begin
                bright = 0;
                peak   = mv[0];
                for (int i = 1; i < 4; i++) begin
                    if (mv[i] > peak) begin
                        peak   = mv[i];
                        bright = i;
                    end
                end
                if (ninety_pct(peak) > mv[bright ^ 1]) begin
                    // Sensors on the left sit at odd positions and swing the other way.
                    delta = (tilt_deg >= 0) ? -10 : 10;
                    if (bright % 2 == 1) delta = -delta;
                    if (pan_deg + delta >= -90 && pan_deg + delta <= 90) begin
                        pan_deg += delta;
                        e.act = sst_pkg::ACT_PAN;
                    end
                end else begin
                    bottom_row = (mv[0] + mv[1]) / 2;
                    top_row    = (mv[2] + mv[3]) / 2;
                    if (top_row <= bottom_row) begin
                        if (ninety_pct(bottom_row) >= top_row && tilt_deg + 10 <= 40) begin
                            tilt_deg += 10;
                            e.act = sst_pkg::ACT_TILT;
                        end
                    end else if (ninety_pct(top_row) >= bottom_row && tilt_deg - 10 >= -40) begin
                        tilt_deg -= 10;
                        e.act = sst_pkg::ACT_TILT;
                    end
                end
            end
            e.pan  = 8'(pan_deg);
            e.tilt = 7'(tilt_deg);
            seen[e.act]++;
            angles_due.push_back(e);
        endfunction

        task flag_error(string msg);
            $display("%0t ps: %s", $time, msg);
            errors++;
        endtask

        task check_angles(logic [23:0] d);
            t_angles e;
            if (angles_due.size() == 0) begin
                flag_error($sformatf("result %h arrived with nothing outstanding", d));
                return;
            end
            e = angles_due.pop_front();
            checked++;
            if (d[1:0] !== e.act)
                flag_error($sformatf("action %0d, expected %0d", d[1:0], e.act));
            if (d[9:2] !== e.pan)
                flag_error($sformatf("pan %0d, expected %0d", $signed(d[9:2]), e.pan));
            if (d[16:10] !== e.tilt)
                flag_error($sformatf("tilt %0d, expected %0d", $signed(d[16:10]), e.tilt));
        endtask
    endclass

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;

    angle_scoreboard sb;
    int  burst_left = 0;
    int  sent       = 0;
    int  phases     = 0;
    int  cycles     = 0;
    bit  hold_req   = 1'b0;

    solar_tracker_servo_stepper_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Offers one item, opening a new burst after a random gap when the current one is spent.
    task automatic send_item(input logic [39:0] d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        sb.note_reading(d);
        sent++;
    endtask

    task automatic send_lux(input int unsigned rb, lb, rt, lt);
        send_item({10'(lt), 10'(rt), 10'(lb), 10'(rb)});
    endtask

    // Stops offering and waits for every outstanding result.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.angles_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [10:0] v);
        settle();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.thr_mv = v;
        phases++;
    endtask

    function automatic logic [39:0] pick_reading(input int fav_sensor, input int fav_row);
        int unsigned v[4];
        int unsigned peak;
        int          sel;
        int          other;
        int          kind;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            foreach (v[i]) v[i] = $urandom_range(0, 1023);
        end else if (kind < 45) begin
            // One sensor well ahead of its row partner, so pan should move.
            sel  = ($urandom_range(0, 2) != 0) ? fav_sensor : $urandom_range(0, 3);
            peak = $urandom_range(500, 1023);
            foreach (v[i]) v[i] = $urandom_range(0, peak);
            v[sel]     = peak;
            v[sel ^ 1] = $urandom_range(0, peak * 85 / 100);
        end else if (kind < 80) begin
            // An even row against a dimmer or similar row, which exercises tilt.
            sel  = ($urandom_range(0, 2) != 0) ? fav_row : $urandom_range(0, 1);
            peak = $urandom_range(450, 1023);
            v[2*sel]     = peak - $urandom_range(0, 30);
            v[2*sel + 1] = peak - $urandom_range(0, 30);
            other = 1 - sel;
            if ($urandom_range(0, 3) == 0) begin
                v[2*other]     = peak - $urandom_range(0, 80);
                v[2*other + 1] = peak - $urandom_range(0, 80);
            end else begin
                v[2*other]     = $urandom_range(0, peak * 8 / 10);
                v[2*other + 1] = $urandom_range(0, peak * 8 / 10);
            end
        end else if (kind < 90) begin
            foreach (v[i]) v[i] = $urandom_range(0, 600);
        end else begin
            peak = $urandom_range(0, 1023);
            foreach (v[i]) v[i] = $urandom_range(0, peak);
            v[$urandom_range(0, 3)] = peak;
            v[$urandom_range(0, 3)] = peak;
        end
        return {10'(v[3]), 10'(v[2]), 10'(v[1]), 10'(v[0])};
    endfunction

    // Output side: checks accepted results and stalls on a random pattern that is redrawn periodically.
    initial begin
        int stall_pct;
        int hold_left;
        int cyc;
        stall_pct = 0;
        hold_left = 0;
        cyc       = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) sb.check_angles(m_tdata);
            if (cyc % 64 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            cyc++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_solar_tracker_servo_stepper_unit: errors");
        $finish;
    end

    initial begin
        int          fav_sensor;
        int          fav_row;
        logic [10:0] thr;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bright bottom right with tilt parked low: pan climbs to its upper stop and sticks.
        repeat (10) send_lux(1000, 100, 500, 500);
        // Even bright bottom row: tilt climbs to its upper stop and sticks.
        repeat (9) send_lux(1000, 990, 600, 600);
        send_lux(1023, 1023, 1023, 1023);
        send_lux(500, 500, 1000, 100);
        send_lux(500, 500, 100, 1000);
        // Three-way tie: the first bright sensor, bottom left, must win.
        send_lux(0, 1000, 1000, 1000);
        send_lux(600, 600, 990, 1000);
        send_lux(0, 0, 0, 0);

        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       thr = 11'd0;
                1:       thr = 11'd1100;
                2:       thr = 11'd300;
                3:       thr = 11'd800;
                6:       thr = 11'd550;
                default: thr = 11'($urandom_range(0, 1100));
            endcase
            write_threshold(thr);
            // With no threshold, complete darkness is daytime and ties on zero.
            if (p == 0) send_item('0);
            if (p == 2) hold_req = 1'b1;
            fav_sensor = $urandom_range(0, 3);
            fav_row    = $urandom_range(0, 1);
            repeat (140) send_item(pick_reading(fav_sensor, fav_row));
        end
        settle();

        $display("Run drove %0d sensor items under %0d threshold settings with a long hold-off.",
                 sent, phases + 1);
        $display("Expected moves: %0d night, %0d pan, %0d tilt, %0d held; %0d results checked.",
                 sb.seen[sst_pkg::ACT_NIGHT], sb.seen[sst_pkg::ACT_PAN],
                 sb.seen[sst_pkg::ACT_TILT], sb.seen[sst_pkg::ACT_NONE], sb.checked);
        if (sb.errors == 0) begin
            $display("tb_solar_tracker_servo_stepper_unit: clean");
        end else begin
            $display("tb_solar_tracker_servo_stepper_unit: errors");
        end
        $finish;
    end
endmodule
